>>> rtl/hpse_pkg.sv
// Shared constants, types and helpers of the H.265 parameter-set extractor.
// No dependencies; used by the window cell, queue cell and top level.
package hpse_pkg;

    localparam int HOLD_DEPTH  = 4;
    localparam int WIN_DEPTH   = HOLD_DEPTH + 1;
    localparam int QUEUE_DEPTH = 8;
    localparam int MAX_BURST   = WIN_DEPTH;
    localparam int WIN_IDX_W   = $clog2(WIN_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] START_BYTE = 8'h01;
    localparam logic [7:0] TYPE_MASK  = 8'h7E;
    localparam logic [5:0] TYPE_VPS   = 6'd32;
    localparam logic [5:0] TYPE_SPS   = 6'd33;
    localparam logic [5:0] TYPE_PPS   = 6'd34;
    localparam logic [2:0] ALL_SEEN   = 3'b111;

    typedef enum logic [1:0] {
        MODE_SEEK,
        MODE_HEADER,
        MODE_PASS,
        MODE_DROP
    } mode_t;

    typedef struct packed {
        logic [7:0] data;
        logic [5:0] unit_type;
        logic       unit_end;
        logic       all_found;
    } result_t;

    typedef struct packed {
        logic advance;
        logic keep;
    } win_ctl_t;

    typedef struct packed {
        logic advance;
        logic load;
    } queue_ctl_t;

    function automatic logic is_param_set(input logic [5:0] t);
        return (t >= TYPE_VPS) && (t <= TYPE_PPS);
    endfunction

    function automatic logic [2:0] seen_bit(input logic [5:0] t);
        logic [2:0] bits;
        bits = 3'b000;
        if (t == TYPE_VPS) begin
            bits = 3'b001;
        end else if (t == TYPE_SPS) begin
            bits = 3'b010;
        end else if (t == TYPE_PPS) begin
            bits = 3'b100;
        end
        return bits;
    endfunction

endpackage

>>> rtl/hpse_win_cell.sv
// One cell of the byte window: a held byte and its valid flag.
// Depends on hpse_pkg for the control struct.
module hpse_win_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  hpse_pkg::win_ctl_t ctl,
    input  logic [7:0]         data_in,
    input  logic               valid_in,
    output logic [7:0]         data_out,
    output logic               valid_out,
    output logic               zero_out
);

    logic [7:0] data_reg;
    logic [7:0] data_next;
    logic       valid_reg;
    logic       valid_next;

    always_comb begin
        data_next  = ctl.advance ? data_in : data_reg;
        valid_next = ctl.advance ? (valid_in & ctl.keep) : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_out  = data_reg;
    assign valid_out = valid_reg;
    assign zero_out  = (data_reg == 8'h00);

endmodule

>>> rtl/hpse_queue_cell.sv
// One cell of the result queue: holds an item, loads a new one or takes its neighbor's.
// Depends on hpse_pkg for the item and control structs.
module hpse_queue_cell (
    input  logic                 aclk,
    input  hpse_pkg::queue_ctl_t ctl,
    input  hpse_pkg::result_t    new_item,
    input  hpse_pkg::result_t    nb_item,
    output hpse_pkg::result_t    item
);

    hpse_pkg::result_t item_reg;
    hpse_pkg::result_t item_next;

    always_comb begin
        if (ctl.load) begin
            item_next = new_item;
        end else if (ctl.advance) begin
            item_next = nb_item;
        end else begin
            item_next = item_reg;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

    assign item = item_reg;

endmodule

>>> rtl/hevc_parameter_set_extractor.sv
// Parameter-set extractor: one input byte per cycle through a four-cell window chain.
// A kept byte leaves once four later bytes arrive, when a start code completes behind
// it, or at stream end, then waits in the eight-cell result queue; one result per cycle
// while m_tready is high. Input is taken while the queue holds three items or fewer (a
// step adds up to five). Reset (aresetn low, synchronous) empties window and queue and
// clears found flags. Depends on hpse_pkg, hpse_win_cell and hpse_queue_cell.
module hevc_parameter_set_extractor (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [6:0] m_tuser,   // [5:0] unit_type, [6] all_found
    output logic       m_tlast
);
    import hpse_pkg::*;

    mode_t             mode_reg;
    mode_t             mode_next;
    logic [5:0]        type_reg;
    logic [5:0]        type_next;
    logic [2:0]        seen_reg;
    logic [2:0]        seen_next;
    logic              finished_reg;
    logic              finished_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    logic [7:0]          wd [HOLD_DEPTH];
    logic [HOLD_DEPTH-1:0] wv;
    logic [HOLD_DEPTH-1:0] wz;
    logic [7:0]          nd [WIN_DEPTH];
    logic [WIN_DEPTH-1:0] nv;
    logic [WIN_DEPTH-1:0] nz;
    win_ctl_t            wctl [HOLD_DEPTH];
    logic [HOLD_DEPTH-1:0] keep;

    logic                 step;
    logic                 last;
    logic                 hdr;
    logic                 detect;
    logic                 code4;
    logic [WIN_IDX_W-1:0] fill;
    logic [WIN_IDX_W-1:0] pre;
    logic [5:0]           hdr_type;
    mode_t                emit_mode;
    logic [5:0]           emit_type;
    logic [WIN_IDX_W-1:0] emit_cnt;
    logic                 emit_end;
    logic                 end_hit;
    logic [2:0]           seen_upd;
    logic                 all_now;
    result_t              batch [MAX_BURST];

    logic                 pop;
    logic [QCNT_W-1:0]    base;
    logic [WIN_IDX_W-1:0] push_cnt;
    result_t              q [QUEUE_DEPTH];
    result_t              q_new [QUEUE_DEPTH];
    result_t              q_nb [QUEUE_DEPTH];
    queue_ctl_t           qctl [QUEUE_DEPTH];

    assign step = s_tvalid && s_tready && !finished_reg;
    assign last = s_tlast;

    // window chain
    always_comb begin
        nd[0] = s_tdata;
        nv[0] = 1'b1;
        nz[0] = (s_tdata == 8'h00);
        for (int i = 1; i < WIN_DEPTH; i++) begin
            nd[i] = wd[i-1];
            nv[i] = wv[i-1];
            nz[i] = wz[i-1];
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < HOLD_DEPTH; gi++) begin : g_win
            assign wctl[gi].advance = step;
            assign wctl[gi].keep    = keep[gi];
            hpse_win_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctl       (wctl[gi]),
                .data_in   (nd[gi]),
                .valid_in  (nv[gi]),
                .data_out  (wd[gi]),
                .valid_out (wv[gi]),
                .zero_out  (wz[gi])
            );
        end
    endgenerate

    // classify and pick results
    always_comb begin
        fill = WIN_IDX_W'(1);
        for (int i = 0; i < HOLD_DEPTH; i++) begin
            fill = fill + WIN_IDX_W'(wv[i]);
        end
        hdr       = (mode_reg == MODE_HEADER);
        hdr_type  = s_tdata[6:1];
        detect    = !hdr && nv[2] && nz[2] && nz[1] && (s_tdata == START_BYTE);
        code4     = nv[3] && nz[3];
        pre       = fill - (code4 ? WIN_IDX_W'(4) : WIN_IDX_W'(3));
        emit_mode = hdr ? (is_param_set(hdr_type) ? MODE_PASS : MODE_DROP) : mode_reg;
        emit_type = hdr ? hdr_type : type_reg;

        priority if (hdr || (!detect && last)) begin
            if (last) begin
                emit_cnt = (emit_mode == MODE_PASS) ? fill : '0;
                emit_end = 1'b1;
            end else begin
                emit_cnt = WIN_IDX_W'((emit_mode == MODE_PASS) && nv[HOLD_DEPTH]);
                emit_end = 1'b0;
            end
        end else if (detect) begin
            emit_cnt = (mode_reg == MODE_PASS) ? pre : '0;
            emit_end = 1'b1;
        end else begin
            emit_cnt = WIN_IDX_W'((mode_reg == MODE_PASS) && nv[HOLD_DEPTH]);
            emit_end = 1'b0;
        end

        end_hit  = emit_end && (emit_cnt != '0);
        seen_upd = seen_reg | seen_bit(emit_type);
        all_now  = (seen_upd == ALL_SEEN);

        for (int j = 0; j < MAX_BURST; j++) begin
            logic [WIN_IDX_W-1:0] idx;
            logic                 is_end;
            idx    = fill - WIN_IDX_W'(1) - WIN_IDX_W'(j);
            is_end = end_hit && (WIN_IDX_W'(j) == emit_cnt - WIN_IDX_W'(1));
            unique case (idx)
                3'd0:    batch[j].data = nd[0];
                3'd1:    batch[j].data = nd[1];
                3'd2:    batch[j].data = nd[2];
                3'd3:    batch[j].data = nd[3];
                3'd4:    batch[j].data = nd[4];
                default: batch[j].data = 8'h00;
            endcase
            batch[j].unit_type = emit_type;
            batch[j].unit_end  = is_end;
            batch[j].all_found = is_end && all_now;
        end

        if (last) begin
            keep = '0;
        end else if (detect && !code4) begin
            keep = HOLD_DEPTH'(4'b0111);
        end else begin
            keep = '1;
        end
    end

    // parser state
    always_comb begin
        mode_next     = mode_reg;
        type_next     = type_reg;
        seen_next     = seen_reg;
        finished_next = finished_reg;
        if (step) begin
            priority if (last) begin
                mode_next = MODE_SEEK;
                type_next = '0;
            end else if (hdr) begin
                mode_next = emit_mode;
                type_next = hdr_type;
            end else if (detect) begin
                mode_next = MODE_HEADER;
                type_next = '0;
            end else begin
                mode_next = mode_reg;
            end
            if (end_hit) begin
                seen_next     = seen_upd;
                finished_next = all_now;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_SEEK;
            type_reg     <= '0;
            seen_reg     <= '0;
            finished_reg <= 1'b0;
            count_reg    <= '0;
        end else begin
            mode_reg     <= mode_next;
            type_reg     <= type_next;
            seen_reg     <= seen_next;
            finished_reg <= finished_next;
            count_reg    <= count_next;
        end
    end

    // result queue
    assign m_tvalid = (count_reg != '0);
    assign pop      = m_tvalid && m_tready;
    assign base     = count_reg - QCNT_W'(pop);
    assign push_cnt = step ? emit_cnt : '0;
    assign count_next = base + QCNT_W'(push_cnt);
    assign s_tready = finished_reg || (count_reg <= QCNT_W'(QUEUE_DEPTH - MAX_BURST));

    genvar gk;
    generate
        for (gk = 0; gk < QUEUE_DEPTH; gk++) begin : g_queue
            logic [QCNT_W-1:0] off;
            logic              below;
            logic              in_batch;
            assign below    = QCNT_W'(gk) < base;
            assign off      = QCNT_W'(gk) - base;
            assign in_batch = !below && (off < QCNT_W'(push_cnt));
            assign qctl[gk].load    = in_batch;
            assign qctl[gk].advance = below && pop;
            assign q_new[gk] = in_batch ? batch[off[WIN_IDX_W-1:0]] : '0;
            if (gk == QUEUE_DEPTH - 1) begin : g_tail
                assign q_nb[gk] = '0;
            end else begin : g_mid
                assign q_nb[gk] = q[gk+1];
            end
            hpse_queue_cell u_cell (
                .aclk     (aclk),
                .ctl      (qctl[gk]),
                .new_item (q_new[gk]),
                .nb_item  (q_nb[gk]),
                .item     (q[gk])
            );
        end
    endgenerate

    assign m_tdata = q[0].data;
    assign m_tuser = {q[0].all_found, q[0].unit_type};
    assign m_tlast = q[0].unit_end;

endmodule

>>> tb/tb.sv
// Self-checking testbench for hevc_parameter_set_extractor: streams Annex B bytes in,
// predicts the forwarded VPS/SPS/PPS bytes and checks every result item in order.
// Depends on hpse_pkg and the hevc_parameter_set_extractor RTL.
module tb;
    import hpse_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int MAX_REPORTS = 40;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] in_byte
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [7:0] out_byte
    logic [6:0] m_tuser;            // [5:0] unit_type, [6] all_found
    logic       m_tlast;

    hevc_parameter_set_extractor u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // parser state mirrored from the stream
    logic [7:0] held_bytes [$];
    mode_t      parse_st = MODE_SEEK;
    logic [5:0] unit_t   = '0;
    logic [2:0] seen_r   = '0;
    logic       found_r  = 1'b0;
    result_t    fwd_q [$];

    // stimulus control shared with the sender and the receiver
    logic [5:0]  held_type;
    logic [5:0]  keep_a;
    logic [5:0]  keep_b;
    logic        allow_held = 1'b0;
    logic [23:0] recent     = 24'hFFFFFF;
    bit          tx_idle    = 1'b1;
    bit          rx_idle    = 1'b1;
    int          rx_hold    = 0;

    int err_cnt      = 0;
    int bytes_sent   = 0;
    int results_seen = 0;
    int units_seen   = 0;
    int cycle_cnt    = 0;

    function automatic void queue_fwd(input logic [7:0] b, input logic ends);
        result_t r;
        if (ends) begin
            if (unit_t >= TYPE_VPS && unit_t <= TYPE_PPS)
                seen_r = seen_r | (3'b001 << (unit_t - TYPE_VPS));
            if (seen_r == ALL_SEEN)
                found_r = 1'b1;
        end
        r.data      = b;
        r.unit_type = unit_t;
        r.unit_end  = ends;
        r.all_found = (seen_r == ALL_SEEN);
        fwd_q.push_back(r);
    endfunction

    function automatic void filter_byte(input logic [7:0] b, input logic stream_last);
        int f;
        int pre;
        if (found_r)
            return;
        held_bytes.push_back(b);
        f = held_bytes.size();
        if (parse_st == MODE_HEADER) begin
            unit_t = 6'((b & TYPE_MASK) >> 1);
            if (unit_t >= TYPE_VPS && unit_t <= TYPE_PPS) begin
                parse_st = MODE_PASS;
            end else begin
                parse_st = MODE_DROP;
            end
        end else if (f >= 3 && held_bytes[f-3] == 8'h00 && held_bytes[f-2] == 8'h00
                     && held_bytes[f-1] == START_BYTE) begin
            pre = (f >= 4 && held_bytes[f-4] == 8'h00) ? f - 4 : f - 3;
            if (parse_st == MODE_PASS) begin
                for (int i = 0; i < pre; i++)
                    queue_fwd(held_bytes[i], i == pre - 1);
            end
            if (found_r)
                return;
            for (int i = 0; i < pre; i++)
                held_bytes.delete(0);
            parse_st = MODE_HEADER;
            unit_t   = '0;
        end
        if (stream_last) begin
            if (parse_st == MODE_PASS) begin
                for (int i = 0; i < held_bytes.size(); i++)
                    queue_fwd(held_bytes[i], i == held_bytes.size() - 1);
            end
            if (!found_r) begin
                held_bytes.delete();
                parse_st = MODE_SEEK;
                unit_t   = '0;
            end
        end else begin
            while (held_bytes.size() > HOLD_DEPTH) begin
                if (parse_st == MODE_PASS)
                    queue_fwd(held_bytes[0], 1'b0);
                held_bytes.delete(0);
            end
        end
    endfunction

    function automatic logic [7:0] type_byte(input logic [5:0] t);
        logic [1:0] spare;
        spare = 2'($urandom_range(0, 3));
        return {spare[1], t, spare[0]};
    endfunction

    // Keep the held-back type out of any header position until the final test.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        logic [7:0] v;
        int         gap;
        v = b;
        if (!allow_held && recent == 24'h000001 && v[6:1] == held_type)
            v[1] = ~v[1];
        recent = {recent[15:0], v};
        gap = tx_idle ? $urandom_range(0, 14) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= fin;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        filter_byte(v, fin);
        bytes_sent++;
    endtask

    task automatic send_code(input logic four, input logic fin);
        if (four)
            send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(START_BYTE, fin);
    endtask

    task automatic report_field(input string field, input int unsigned want,
                                input int unsigned got);
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
            $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
    endtask

    task automatic check_result();
        result_t want;
        results_seen++;
        if (m_tlast)
            units_seen++;
        if (fwd_q.size() == 0) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
                $error("unexpected item: out_byte 0x%0h unit_type %0d", m_tdata, m_tuser[5:0]);
        end else begin
            want = fwd_q.pop_front();
            if (m_tdata !== want.data)
                report_field("out_byte", want.data, m_tdata);
            if (m_tuser[5:0] !== want.unit_type)
                report_field("unit_type", want.unit_type, m_tuser[5:0]);
            if (m_tlast !== want.unit_end)
                report_field("unit_end", want.unit_end, m_tlast);
            if (m_tuser[6] !== want.all_found)
                report_field("all_found", want.all_found, m_tuser[6]);
        end
    endtask

    initial begin : result_sink
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = rx_idle ? $urandom_range(0, 14) : 0;
            if (rx_hold > 0) begin
                stall   = rx_hold;
                rx_hold = 0;
            end
            @(negedge aclk);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            check_result();
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // leading junk, both code lengths, repeated type, type byte zero, code at stream end
    task automatic test_directed();
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_code(1'b1, 1'b0);
        send_byte(type_byte(keep_a), 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_code(1'b0, 1'b0);
        send_byte(type_byte(keep_b), 1'b0);
        send_byte(8'h12, 1'b0);
        send_code(1'b0, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(START_BYTE, 1'b0);
        send_byte(type_byte(keep_a), 1'b0);
        send_byte(8'h80, 1'b1);
        send_code(1'b0, 1'b1);
    endtask

    task automatic test_random_streams(input int n_bytes);
        int         stop_at;
        int         pick;
        int         len;
        logic [5:0] t;
        logic [7:0] b;
        logic       ends_stream;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            if ($urandom_range(0, 9) == 0)
                tx_idle = ~tx_idle;
            if ($urandom_range(0, 9) == 0)
                rx_idle = ~rx_idle;
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                    send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
            end else if (pick < 17) begin
                send_code(1'($urandom_range(0, 1)), 1'b1);
            end else begin
                send_code(1'($urandom_range(0, 1)), 1'b0);
                if ($urandom_range(0, 99) < 55) begin
                    t = $urandom_range(0, 1) ? keep_a : keep_b;
                end else begin
                    t = 6'($urandom_range(0, 63));
                end
                pick = $urandom_range(0, 99);
                if (pick < 10) begin
                    len = 0;
                end else if (pick < 85) begin
                    len = $urandom_range(1, 8);
                end else begin
                    len = $urandom_range(9, 24);
                end
                ends_stream = ($urandom_range(0, 99) < 15);
                send_byte(type_byte(t), ends_stream && len == 0);
                for (int i = 0; i < len; i++) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 30) begin
                        b = 8'h00;
                    end else if (pick < 40) begin
                        b = START_BYTE;
                    end else if (pick < 45) begin
                        b = 8'h03;
                    end else begin
                        b = 8'($urandom_range(0, 255));
                    end
                    send_byte(b, ends_stream && i == len - 1);
                end
            end
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    // long kept unit while the receiver holds off, so the block must stall its input
    task automatic test_backpressure();
        tx_idle = 1'b0;
        rx_hold = 300;
        send_code(1'b0, 1'b0);
        send_byte(type_byte(keep_b), 1'b0);
        for (int i = 0; i < 60; i++)
            send_byte(8'($urandom_range(2, 255)), i == 59);
        tx_idle = 1'b1;
    endtask

    // complete the last missing type, then check that everything after is dropped
    task automatic test_all_found();
        allow_held = 1'b1;
        send_byte(8'hAB, 1'b1);
        send_code(1'b1, 1'b0);
        send_byte(type_byte(held_type), 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_code(1'b1, 1'b0);
        send_byte(type_byte(keep_a), 1'b0);
        send_byte(8'h77, 1'b0);
        send_code(1'b0, 1'b0);
        send_byte(type_byte(held_type), 1'b0);
        send_byte(8'h10, 1'b1);
        send_code(1'b0, 1'b0);
        send_byte(type_byte(keep_b), 1'b0);
        send_byte(8'h21, 1'b1);
    endtask

    initial begin
        held_type = TYPE_VPS + 6'($urandom_range(0, 2));
        keep_a    = (held_type == TYPE_VPS) ? TYPE_SPS : TYPE_VPS;
        keep_b    = (held_type == TYPE_PPS) ? TYPE_SPS : TYPE_PPS;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_random_streams(330);
        test_backpressure();
        test_all_found();

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (fwd_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        $display("sent %0d stream bytes; checked %0d forwarded bytes in %0d kept units",
                 bytes_sent, results_seen, units_seen);
        $display("held-back type %0d completed last, %0d field errors", held_type, err_cnt);
        if (err_cnt == 0 && fwd_q.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
